@@ rtl/core/ghsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ghsp_pkg
// Shared types, codes and tables of the model file header stream parser.
// ----------------------------------------------------------------------------
package ghsp_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC    = 5'd0,
    PH_VERSION  = 5'd1,
    PH_NTENS    = 5'd2,
    PH_NKV      = 5'd3,
    PH_KEYLEN   = 5'd4,
    PH_KEYSKIP  = 5'd5,
    PH_VTYPE    = 5'd6,
    PH_VSKIP    = 5'd7,
    PH_STRLEN   = 5'd8,
    PH_ARRTYPE  = 5'd9,
    PH_ARRLEN   = 5'd10,
    PH_ASKIP    = 5'd11,
    PH_ASTRLEN  = 5'd12,
    PH_NAMELEN  = 5'd13,
    PH_NAMEBYTE = 5'd14,
    PH_NDIMS    = 5'd15,
    PH_TTYPE    = 5'd16,
    PH_DIM      = 5'd17,
    PH_TOFF     = 5'd18,
    PH_DONE     = 5'd19,
    PH_ERROR    = 5'd20
  } phase_t;

  localparam logic [3:0] KIND_VERSION  = 4'd0;
  localparam logic [3:0] KIND_NTENS    = 4'd1;
  localparam logic [3:0] KIND_NKV      = 4'd2;
  localparam logic [3:0] KIND_NAMELEN  = 4'd3;
  localparam logic [3:0] KIND_NAMEBYTE = 4'd4;
  localparam logic [3:0] KIND_NDIMS    = 4'd5;
  localparam logic [3:0] KIND_TTYPE    = 4'd6;
  localparam logic [3:0] KIND_DIM      = 4'd7;
  localparam logic [3:0] KIND_TOFF     = 4'd8;
  localparam logic [3:0] KIND_END      = 4'd9;
  localparam logic [3:0] KIND_ERROR    = 4'd10;

  localparam logic [63:0] ERR_MAGIC     = 64'd0;
  localparam logic [63:0] ERR_TRUNC     = 64'd1;
  localparam logic [63:0] ERR_TYPE      = 64'd2;
  localparam logic [63:0] ERR_ARRTYPE   = 64'd3;

  localparam logic [63:0] MAGIC_WORD    = 64'h0000_0000_4655_4747;
  localparam logic [3:0]  TYPE_STRING   = 4'd11;
  localparam logic [3:0]  TYPE_ARRAY    = 4'd12;
  localparam logic [3:0]  ELEM_BAD      = 4'd15;

  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [63:0] tensor_number;
    logic [31:0] dim_number;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic logic [3:0] scalar_size(logic [3:0] k);
    logic [3:0] s;
    case (k)
      4'd0, 4'd1, 4'd2:    s = 4'd1;
      4'd3, 4'd4:          s = 4'd2;
      4'd5, 4'd6, 4'd7:    s = 4'd4;
      4'd8, 4'd9, 4'd10:   s = 4'd8;
      default:             s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/ghsp_parse.sv @@
// ----------------------------------------------------------------------------
// ghsp_parse
// Header parse state and the per-byte update, up to two records per byte.
// ----------------------------------------------------------------------------
module ghsp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  output ghsp_pkg::res_pair_t res
);

  ghsp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [63:0] facc_r, facc_nxt;
  logic [63:0] soff_r, soff_nxt;
  logic [63:0] kv_r, kv_nxt;
  logic [63:0] ttot_r, ttot_nxt;
  logic [63:0] tcur_r, tcur_nxt;
  logic [31:0] dims_r, dims_nxt;
  logic [31:0] dcur_r, dcur_nxt;
  logic [63:0] skip_r, skip_nxt;
  logic [63:0] arr_r, arr_nxt;
  logic [3:0]  akind_r, akind_nxt;

  always_comb begin
    logic [3:0]          glen;
    logic [3:0]          fbc_inc;
    logic [63:0]         acc;
    logic                gdone;
    logic                is_gather;
    logic [63:0]         cd;
    logic                cd_done;
    logic                do_nai, do_after, do_bkv, do_bt;
    logic                m_v, x_v;
    ghsp_pkg::res_t      m_res, x_res, e0, e1;
    logic [1:0]          n;

    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    facc_nxt  = facc_r;
    soff_nxt  = soff_r;
    kv_nxt    = kv_r;
    ttot_nxt  = ttot_r;
    tcur_nxt  = tcur_r;
    dims_nxt  = dims_r;
    dcur_nxt  = dcur_r;
    skip_nxt  = skip_r;
    arr_nxt   = arr_r;
    akind_nxt = akind_r;

    glen = 4'd8;
    if (phase_r == ghsp_pkg::PH_MAGIC || phase_r == ghsp_pkg::PH_VERSION ||
        phase_r == ghsp_pkg::PH_VTYPE || phase_r == ghsp_pkg::PH_ARRTYPE ||
        phase_r == ghsp_pkg::PH_NDIMS || phase_r == ghsp_pkg::PH_TTYPE) begin
      glen = 4'd4;
    end
    is_gather = !(phase_r == ghsp_pkg::PH_KEYSKIP || phase_r == ghsp_pkg::PH_VSKIP ||
                  phase_r == ghsp_pkg::PH_ASKIP || phase_r == ghsp_pkg::PH_NAMEBYTE);
    acc     = facc_r | ({56'd0, data_byte} << {fbc_r[2:0], 3'b000});
    fbc_inc = fbc_r + 4'd1;
    gdone   = fbc_inc >= glen;
    cd      = skip_r - {63'd0, (skip_r != 64'd0)};
    cd_done = cd == 64'd0;

    do_nai   = 1'b0;
    do_after = 1'b0;
    do_bkv   = 1'b0;
    do_bt    = 1'b0;
    m_v      = 1'b0;
    x_v      = 1'b0;
    m_res    = '0;
    x_res    = '0;
    e0       = '0;
    e1       = '0;
    n        = 2'd0;

    if (fire) begin
      if (phase_r == ghsp_pkg::PH_DONE || phase_r == ghsp_pkg::PH_ERROR) begin
        // trailing bytes dropped, end of file rearms below
      end else begin
        soff_nxt = soff_r + 64'd1;
        if (is_gather) begin
          fbc_nxt  = gdone ? 4'd0 : fbc_inc;
          facc_nxt = gdone ? 64'd0 : acc;
        end

        unique case (phase_r)
          ghsp_pkg::PH_MAGIC: begin
            if (gdone) begin
              if (acc != ghsp_pkg::MAGIC_WORD) begin
                m_v = 1'b1;
                m_res.kind  = ghsp_pkg::KIND_ERROR;
                m_res.value = ghsp_pkg::ERR_MAGIC;
                phase_nxt = ghsp_pkg::PH_ERROR;
              end else begin
                phase_nxt = ghsp_pkg::PH_VERSION;
              end
            end
          end
          ghsp_pkg::PH_VERSION: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind  = ghsp_pkg::KIND_VERSION;
              m_res.value = acc;
              phase_nxt = ghsp_pkg::PH_NTENS;
            end
          end
          ghsp_pkg::PH_NTENS: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind  = ghsp_pkg::KIND_NTENS;
              m_res.value = acc;
              ttot_nxt  = acc;
              phase_nxt = ghsp_pkg::PH_NKV;
            end
          end
          ghsp_pkg::PH_NKV: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind  = ghsp_pkg::KIND_NKV;
              m_res.value = acc;
              kv_nxt = acc;
              do_bkv = 1'b1;
            end
          end
          ghsp_pkg::PH_KEYLEN: begin
            if (gdone) begin
              skip_nxt  = acc;
              phase_nxt = (acc == 64'd0) ? ghsp_pkg::PH_VTYPE : ghsp_pkg::PH_KEYSKIP;
            end
          end
          ghsp_pkg::PH_KEYSKIP: begin
            skip_nxt = cd;
            if (cd_done) phase_nxt = ghsp_pkg::PH_VTYPE;
          end
          ghsp_pkg::PH_VTYPE: begin
            if (gdone) begin
              if (acc < {60'd0, ghsp_pkg::TYPE_STRING}) begin
                skip_nxt  = {60'd0, ghsp_pkg::scalar_size(acc[3:0])};
                phase_nxt = ghsp_pkg::PH_VSKIP;
              end else if (acc == {60'd0, ghsp_pkg::TYPE_STRING}) begin
                phase_nxt = ghsp_pkg::PH_STRLEN;
              end else if (acc == {60'd0, ghsp_pkg::TYPE_ARRAY}) begin
                phase_nxt = ghsp_pkg::PH_ARRTYPE;
              end else begin
                m_v = 1'b1;
                m_res.kind  = ghsp_pkg::KIND_ERROR;
                m_res.value = ghsp_pkg::ERR_TYPE;
                phase_nxt = ghsp_pkg::PH_ERROR;
              end
            end
          end
          ghsp_pkg::PH_VSKIP: begin
            skip_nxt = cd;
            if (cd_done) do_after = 1'b1;
          end
          ghsp_pkg::PH_STRLEN: begin
            if (gdone) begin
              if (acc == 64'd0) begin
                do_after = 1'b1;
              end else begin
                skip_nxt  = acc;
                phase_nxt = ghsp_pkg::PH_VSKIP;
              end
            end
          end
          ghsp_pkg::PH_ARRTYPE: begin
            if (gdone) begin
              akind_nxt = (acc <= {60'd0, ghsp_pkg::TYPE_STRING}) ? acc[3:0]
                                                                  : ghsp_pkg::ELEM_BAD;
              phase_nxt = ghsp_pkg::PH_ARRLEN;
            end
          end
          ghsp_pkg::PH_ARRLEN: begin
            if (gdone) begin
              if (akind_r == ghsp_pkg::ELEM_BAD) begin
                m_v = 1'b1;
                m_res.kind  = ghsp_pkg::KIND_ERROR;
                m_res.value = ghsp_pkg::ERR_ARRTYPE;
                phase_nxt = ghsp_pkg::PH_ERROR;
              end else begin
                arr_nxt = acc;
                do_nai  = 1'b1;
              end
            end
          end
          ghsp_pkg::PH_ASKIP: begin
            skip_nxt = cd;
            if (cd_done) do_nai = 1'b1;
          end
          ghsp_pkg::PH_ASTRLEN: begin
            if (gdone) begin
              if (acc == 64'd0) begin
                do_nai = 1'b1;
              end else begin
                skip_nxt  = acc;
                phase_nxt = ghsp_pkg::PH_ASKIP;
              end
            end
          end
          ghsp_pkg::PH_NAMELEN: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind          = ghsp_pkg::KIND_NAMELEN;
              m_res.value         = acc;
              m_res.tensor_number = tcur_r;
              skip_nxt  = acc;
              phase_nxt = (acc == 64'd0) ? ghsp_pkg::PH_NDIMS : ghsp_pkg::PH_NAMEBYTE;
            end
          end
          ghsp_pkg::PH_NAMEBYTE: begin
            m_v = 1'b1;
            m_res.kind          = ghsp_pkg::KIND_NAMEBYTE;
            m_res.value         = {56'd0, data_byte};
            m_res.tensor_number = tcur_r;
            skip_nxt = cd;
            if (cd_done) phase_nxt = ghsp_pkg::PH_NDIMS;
          end
          ghsp_pkg::PH_NDIMS: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind          = ghsp_pkg::KIND_NDIMS;
              m_res.value         = acc;
              m_res.tensor_number = tcur_r;
              dims_nxt  = acc[31:0];
              dcur_nxt  = 32'd0;
              phase_nxt = ghsp_pkg::PH_TTYPE;
            end
          end
          ghsp_pkg::PH_TTYPE: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind          = ghsp_pkg::KIND_TTYPE;
              m_res.value         = acc;
              m_res.tensor_number = tcur_r;
              phase_nxt = (dims_r != 32'd0) ? ghsp_pkg::PH_DIM : ghsp_pkg::PH_TOFF;
            end
          end
          ghsp_pkg::PH_DIM: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind          = ghsp_pkg::KIND_DIM;
              m_res.value         = acc;
              m_res.tensor_number = tcur_r;
              m_res.dim_number    = dcur_r;
              dcur_nxt = dcur_r + 32'd1;
              dims_nxt = dims_r - 32'd1;
              if (dims_r == 32'd1) phase_nxt = ghsp_pkg::PH_TOFF;
            end
          end
          ghsp_pkg::PH_TOFF: begin
            if (gdone) begin
              m_v = 1'b1;
              m_res.kind          = ghsp_pkg::KIND_TOFF;
              m_res.value         = acc;
              m_res.tensor_number = tcur_r;
              tcur_nxt = tcur_r + 64'd1;
              do_bt    = 1'b1;
            end
          end
          default: begin
            phase_nxt = ghsp_pkg::PH_ERROR;
          end
        endcase

        // next array element, or the value ends when none are left
        if (do_nai) begin
          if (arr_nxt == 64'd0) begin
            do_after = 1'b1;
          end else begin
            arr_nxt = arr_nxt - 64'd1;
            if (akind_r == ghsp_pkg::TYPE_STRING) begin
              phase_nxt = ghsp_pkg::PH_ASTRLEN;
            end else begin
              skip_nxt  = {60'd0, ghsp_pkg::scalar_size(akind_r)};
              phase_nxt = ghsp_pkg::PH_ASKIP;
            end
          end
        end
        if (do_after) begin
          kv_nxt = kv_nxt - 64'd1;
          do_bkv = 1'b1;
        end
        if (do_bkv) begin
          if (kv_nxt == 64'd0) do_bt = 1'b1;
          else phase_nxt = ghsp_pkg::PH_KEYLEN;
        end
        if (do_bt) begin
          phase_nxt = (tcur_nxt == ttot_nxt) ? ghsp_pkg::PH_DONE : ghsp_pkg::PH_NAMELEN;
        end

        if (phase_nxt == ghsp_pkg::PH_DONE) begin
          x_v = 1'b1;
          x_res.kind  = ghsp_pkg::KIND_END;
          x_res.value = soff_nxt;
        end else if (phase_nxt != ghsp_pkg::PH_ERROR && end_of_file) begin
          x_v = 1'b1;
          x_res.kind  = ghsp_pkg::KIND_ERROR;
          x_res.value = ghsp_pkg::ERR_TRUNC;
          phase_nxt = ghsp_pkg::PH_ERROR;
        end

        if (m_v && x_v) begin
          e0 = m_res;
          e1 = x_res;
          e1.run_end = 1'b1;
          n = 2'd2;
        end else if (m_v) begin
          e0 = m_res;
          e0.run_end = 1'b1;
          n = 2'd1;
        end else if (x_v) begin
          e0 = x_res;
          e0.run_end = 1'b1;
          n = 2'd1;
        end
      end

      if (end_of_file) begin
        phase_nxt = ghsp_pkg::PH_MAGIC;
        fbc_nxt   = 4'd0;
        facc_nxt  = 64'd0;
        soff_nxt  = 64'd0;
        kv_nxt    = 64'd0;
        ttot_nxt  = 64'd0;
        tcur_nxt  = 64'd0;
        dims_nxt  = 32'd0;
        dcur_nxt  = 32'd0;
        skip_nxt  = 64'd0;
        arr_nxt   = 64'd0;
        akind_nxt = 4'd0;
      end
    end

    res.count = n;
    res.r0    = e0;
    res.r1    = e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ghsp_pkg::PH_MAGIC;
      fbc_r   <= 4'd0;
      facc_r  <= 64'd0;
      soff_r  <= 64'd0;
      kv_r    <= 64'd0;
      ttot_r  <= 64'd0;
      tcur_r  <= 64'd0;
      dims_r  <= 32'd0;
      dcur_r  <= 32'd0;
      skip_r  <= 64'd0;
      arr_r   <= 64'd0;
      akind_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      facc_r  <= facc_nxt;
      soff_r  <= soff_nxt;
      kv_r    <= kv_nxt;
      ttot_r  <= ttot_nxt;
      tcur_r  <= tcur_nxt;
      dims_r  <= dims_nxt;
      dcur_r  <= dcur_nxt;
      skip_r  <= skip_nxt;
      arr_r   <= arr_nxt;
      akind_r <= akind_nxt;
    end
  end

endmodule

@@ rtl/core/ghsp_res_fifo.sv @@
// ----------------------------------------------------------------------------
// ghsp_res_fifo
// Record queue: takes up to two records a cycle, hands out one when popped.
// ----------------------------------------------------------------------------
module ghsp_res_fifo #(
  parameter int Depth = ghsp_pkg::RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ghsp_pkg::res_pair_t push,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output ghsp_pkg::res_t      head
);

  localparam int AW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  ghsp_pkg::res_t mem [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW-1:0] wp1, wp2;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign wp1        = (wp_r == LAST) ? '0 : wp_r + AW'(1);
  assign wp2        = (wp1 == LAST) ? '0 : wp1 + AW'(1);
  assign head_valid = cnt_r != '0;
  assign head       = mem[rp_r];
  assign room       = cnt_r <= CW'(Depth - 2);
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt = wp_r;
    case (push.count)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = wp2;
      default: wp_nxt = wp_r;
    endcase
    rp_nxt  = do_pop ? ((rp_r == LAST) ? '0 : rp_r + AW'(1)) : rp_r;
    cnt_nxt = cnt_r + CW'(push.count) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wp_r] <= push.r0;
    if (push.count == 2'd2) mem[wp1] <= push.r1;
  end

endmodule

@@ rtl/core/gguf_header_stream_parser.sv @@
// ----------------------------------------------------------------------------
// gguf_header_stream_parser
// Parses a model file header from a byte stream and reports its records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | data_byte, end_of_file
//  out_    | output    | out_valid / out_stall | kind, value, tensor_number,
//          |           |                       | dim_number, run_end
//
//  one byte per cycle while in_stall is low; a byte waits in the input register
//  until the queue has room, its records are then registered in the record queue
//  and show one per cycle while out_stall is low; a second record waits there
//  input stalls only while the queue cannot take two more records
//  synchronous active-low reset; no clearing pass
// ----------------------------------------------------------------------------
module gguf_header_stream_parser #(
  parameter int ResDepth = ghsp_pkg::RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [63:0] out_value,
  output logic [63:0] out_tensor_number,
  output logic [31:0] out_dim_number,
  output logic        out_run_end
);

  logic                stage_v_r, stage_v_nxt;
  logic [7:0]          byte_r;
  logic                eof_r;
  logic                room;
  logic                fire;
  logic                accept;
  ghsp_pkg::res_pair_t pair;
  ghsp_pkg::res_t      head;

  assign fire        = stage_v_r && room;
  assign in_stall    = stage_v_r && !room;
  assign accept      = in_valid && !in_stall;
  assign stage_v_nxt = accept ? 1'b1 : (fire ? 1'b0 : stage_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) stage_v_r <= 1'b0;
    else        stage_v_r <= stage_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      eof_r  <= in_end_of_file;
    end
  end

  ghsp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (byte_r),
    .end_of_file (eof_r),
    .res         (pair)
  );

  ghsp_res_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (pair),
    .pop        (!out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_kind          = head.kind;
  assign out_value         = head.value;
  assign out_tensor_number = head.tensor_number;
  assign out_dim_number    = head.dim_number;
  assign out_run_end       = head.run_end;

endmodule
